[hw/rtl/nat_pkg.sv]
// shared types, codes and reset constants of the port-translation table
package nat_pkg;

  localparam int unsigned TableDepth = 64;

  localparam logic [31:0] ResetPublicAddr = 32'd0;
  localparam logic [15:0] ResetFirstPort  = 16'd1025;
  localparam logic [15:0] ResetLastPort   = 16'd65000;

  typedef enum logic [1:0] {
    RegPublicAddr = 2'd0,
    RegFirstPort  = 2'd1,
    RegLastPort   = 2'd2
  } nat_reg_e;

  typedef enum logic [1:0] {
    StHit  = 2'd0,
    StNew  = 2'd1,
    StMiss = 2'd2,
    StFull = 2'd3
  } nat_status_e;

  typedef struct packed {
    logic        action;
    logic        proto;
    logic [31:0] inside_address;
    logic [15:0] key_port;
  } nat_in_t;

  typedef struct packed {
    nat_status_e status;
    logic [31:0] mapped_address;
    logic [15:0] mapped_port;
  } nat_out_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] inside_address;
    logic [15:0] inside_port;
    logic [15:0] outside_port;
  } nat_entry_t;

  // lookup token moving down the cell chain
  typedef struct packed {
    logic        valid;
    logic        action;
    logic        kind;
    logic [31:0] addr;
    logic [15:0] port;
    logic        hit;
    logic [31:0] res_addr;
    logic [15:0] res_port;
  } nat_tok_t;

endpackage

[hw/rtl/nat_cell.sv]
// one table cell: holds an entry, compares the passing token and forwards it
module nat_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              live_i,
  input  logic              wr_en_i,
  input  nat_pkg::nat_entry_t wr_entry_i,
  input  nat_pkg::nat_tok_t tok_i,
  output nat_pkg::nat_tok_t tok_o
);

  nat_pkg::nat_entry_t entry_q;
  nat_pkg::nat_tok_t   tok_d;
  nat_pkg::nat_tok_t   tok_q;
  logic                match;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_entry_i;
    end
  end

  always_comb begin
    if (tok_i.action) begin
      match = entry_q.kind == tok_i.kind && entry_q.outside_port == tok_i.port;
    end else begin
      match = entry_q.kind == tok_i.kind && entry_q.inside_port == tok_i.port &&
              entry_q.inside_address == tok_i.addr;
    end
    match = match && live_i && tok_i.valid && !tok_i.hit;

    tok_d = tok_i;
    if (match) begin
      tok_d.hit      = 1'b1;
      tok_d.res_addr = entry_q.inside_address;
      tok_d.res_port = tok_i.action ? entry_q.inside_port : entry_q.outside_port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[hw/rtl/nat_translation_table.sv]
// top level of the port-translation table: cell chain, allocator and result register
//
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i / in_stall_o  | in_item_i  (nat_in_t)
//  out     | out | out_valid_o / out_stall_i| out_item_o (nat_out_t)
//  cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// an item's lookup token walks the cell chain one cell per cycle and is
// captured in done_q, then the SDone state settles the result and any
// append once the output register is free; one item is in flight at a time
// reset empties the table and loads the port counter with the reset first port
// a finished result waits in the output register while the next item enters
module nat_translation_table #(
  parameter int unsigned TABLE_DEPTH = nat_pkg::TableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nat_pkg::nat_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nat_pkg::nat_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  nat_pkg::nat_reg_e cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SScan = 3'b010,
    SDone = 3'b100
  } nat_state_e;

  nat_state_e state_q, state_d;

  logic [31:0]     public_q;
  logic [15:0]     first_q;
  logic [15:0]     last_q;
  logic [15:0]     next_q, next_d;
  logic [CntW-1:0] count_q, count_d;

  nat_pkg::nat_tok_t   tok [TABLE_DEPTH+1];
  nat_pkg::nat_tok_t   tok_in;
  nat_pkg::nat_tok_t   done_q;
  nat_pkg::nat_entry_t wr_entry;
  logic                append;
  logic                full;
  logic                out_free;
  logic                finish;
  logic [15:0]         given;

  logic              out_valid_q, out_valid_d;
  nat_pkg::nat_out_t out_q, out_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != SIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      public_q <= nat_pkg::ResetPublicAddr;
      first_q  <= nat_pkg::ResetFirstPort;
      last_q   <= nat_pkg::ResetLastPort;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nat_pkg::RegPublicAddr: public_q <= cfg_data_i;
        nat_pkg::RegFirstPort:  first_q  <= cfg_data_i[15:0];
        nat_pkg::RegLastPort:   last_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // token injected into the first cell
  always_comb begin
    tok_in.valid    = in_valid_i && !in_stall_o;
    tok_in.action   = in_item_i.action;
    tok_in.kind     = in_item_i.proto;
    tok_in.addr     = in_item_i.inside_address;
    tok_in.port     = in_item_i.key_port;
    tok_in.hit      = 1'b0;
    tok_in.res_addr = 32'd0;
    tok_in.res_port = 16'd0;
  end

  assign tok[0] = tok_in;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nat_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .live_i     (CntW'(i) < count_q),
      .wr_en_i    (append && count_q[IdxW-1:0] == IdxW'(i)),
      .wr_entry_i (wr_entry),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  assign full     = count_q == CntW'(TABLE_DEPTH);
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = state_q == SDone && out_free;
  assign append   = finish && !done_q.action && !done_q.hit && !full;

  always_comb begin
    if (next_q == last_q) begin
      given  = first_q;
      next_d = first_q + 16'd1;
    end else begin
      given  = next_q;
      next_d = next_q + 16'd1;
    end
    wr_entry.kind           = done_q.kind;
    wr_entry.inside_address = done_q.addr;
    wr_entry.inside_port    = done_q.port;
    wr_entry.outside_port   = given;
    count_d                 = count_q + CntW'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (tok_in.valid) state_d = SScan;
      SScan: if (tok[TABLE_DEPTH].valid) state_d = SDone;
      SDone: if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (done_q.hit) begin
      out_d.status         = nat_pkg::StHit;
      out_d.mapped_address = done_q.action ? done_q.res_addr : public_q;
      out_d.mapped_port    = done_q.res_port;
    end else if (done_q.action) begin
      out_d.status         = nat_pkg::StMiss;
      out_d.mapped_address = 32'd0;
      out_d.mapped_port    = 16'd0;
    end else if (full) begin
      out_d.status         = nat_pkg::StFull;
      out_d.mapped_address = 32'd0;
      out_d.mapped_port    = 16'd0;
    end else begin
      out_d.status         = nat_pkg::StNew;
      out_d.mapped_address = public_q;
      out_d.mapped_port    = given;
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      next_q      <= nat_pkg::ResetFirstPort;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (append) begin
        count_q <= count_d;
        next_q  <= next_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SScan && tok[TABLE_DEPTH].valid) begin
      done_q <= tok[TABLE_DEPTH];
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hw/rtl/nat_chk.sv]
// port checker for the port-translation table, bound to the top level
module nat_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input nat_pkg::nat_out_t out_item_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one item in flight: busy right after accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while lookup in progress");

  // no result can appear the cycle after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // misses and full carry zero mapping
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == nat_pkg::StMiss ||
                    out_item_o.status == nat_pkg::StFull)
    |-> out_item_o.mapped_address == 32'd0 && out_item_o.mapped_port == 16'd0)
    else $error("nonzero mapping on miss or full");

endmodule

bind nat_translation_table nat_chk u_nat_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
